/* hw/rtl/csrb_pkg.sv */
// Shared types and constants for the clipped sprite/rect blitter.
`default_nettype none
package csrb_pkg;

  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 160;

  localparam int POS_X_W   = 9;
  localparam int POS_Y_W   = 10;
  localparam int EXTENT_W  = 8;
  localparam int PIX_W     = 8;
  localparam int ADDR_W    = 15;
  localparam int COORD_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT_KEY = 2'd1;

  localparam logic [PIX_W-1:0] COLOR_BLACK = 8'h00;

  typedef enum logic [1:0] {
    MODE_SPRITE  = 2'd0,
    MODE_OUTLINE = 2'd1,
    MODE_FILL    = 2'd2,
    MODE_ERASE   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   value;
    logic               use_bg;
  } blit_entry_t;

  typedef struct packed {
    logic        push;
    blit_entry_t entry;
  } queue_wr_t;

endpackage
`default_nettype wire

/* hw/rtl/csrb_front.sv */
// Front end: config registers, shape latch, clipping and per-pixel classification.
`default_nettype none
module csrb_front #(
  parameter int SCREEN_WIDTH  = csrb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = csrb_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_cmd,
  input  logic signed [csrb_pkg::POS_X_W-1:0]    in_pos_x,
  input  logic signed [csrb_pkg::POS_Y_W-1:0]    in_pos_y,
  input  logic [csrb_pkg::EXTENT_W-1:0]          in_shape_width,
  input  logic [csrb_pkg::EXTENT_W-1:0]          in_shape_height,
  input  logic [1:0]                             in_mode,
  input  logic [csrb_pkg::PIX_W-1:0]             in_draw_color,
  input  logic [csrb_pkg::PIX_W-1:0]             in_src_pixel,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [csrb_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [csrb_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   q_full,
  output csrb_pkg::queue_wr_t                    q_wr
);
  import csrb_pkg::*;

  localparam logic signed [11:0] SW12   = 12'(SCREEN_WIDTH);
  localparam logic signed [11:0] SH12   = 12'(SCREEN_HEIGHT);
  localparam logic signed [11:0] SH_M1  = 12'(SCREEN_HEIGHT - 1);

  logic                      bg_mode_r;
  logic [PIX_W-1:0]          key_r;
  logic signed [POS_X_W-1:0] origin_x_r;
  logic signed [POS_Y_W-1:0] origin_y_r;
  logic [EXTENT_W-1:0]       extent_w_r;
  logic [EXTENT_W-1:0]       extent_h_r;
  mode_t                     shape_mode_r;
  logic [PIX_W-1:0]          shape_color_r;
  logic [EXTENT_W-1:0]       col_count_r, col_count_nxt;
  logic [EXTENT_W-1:0]       row_count_r, row_count_nxt;
  logic                      rejected_r;

  logic                      in_accept;
  logic signed [11:0]        x12, y12, w12, h12;
  logic                      off;
  logic                      active;
  logic [EXTENT_W:0]         col_inc;
  logic signed [11:0]        col_s, row_s;
  logic                      visible;
  logic [PIX_W-1:0]          value;
  logic                      use_bg;

  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;

  assign x12 = 12'(in_pos_x);
  assign y12 = 12'(in_pos_y);
  assign w12 = signed'({4'b0, in_shape_width});
  assign h12 = signed'({4'b0, in_shape_height});

  assign off = (x12 >= SW12) || ((y12 - h12 + 12'sd1) >= SH12) || ((x12 + w12) <= 12'sd0) ||
               (y12 < 12'sd0) || (w12 > SW12) || (h12 > SH12) ||
               (in_shape_width == '0) || (in_shape_height == '0);

  assign active  = !rejected_r && (row_count_r < extent_h_r) && (extent_w_r != '0);
  assign col_inc = {1'b0, col_count_r} + 1'b1;
  assign col_s   = 12'(origin_x_r) + signed'({4'b0, col_count_r});
  assign row_s   = SH_M1 - 12'(origin_y_r) + signed'({4'b0, row_count_r});
  assign visible = (col_s >= 12'sd0) && (col_s < SW12) && (row_s >= 12'sd0) && (row_s < SH12);

  always_comb begin
    value  = '0;
    use_bg = 1'b0;
    unique case (shape_mode_r)
      MODE_SPRITE: begin
        if (in_src_pixel != key_r) begin
          value = in_src_pixel;
        end else if (bg_mode_r) begin
          use_bg = 1'b1;
        end else begin
          value = COLOR_BLACK;
        end
      end
      MODE_OUTLINE: begin
        if (row_count_r == '0 || row_count_r == extent_h_r - 1'b1 ||
            col_count_r == '0 || col_count_r == extent_w_r - 1'b1) begin
          value = shape_color_r;
        end else begin
          use_bg = 1'b1;
        end
      end
      MODE_FILL:  value  = shape_color_r;
      MODE_ERASE: use_bg = 1'b1;
      default:    use_bg = 1'b1;
    endcase
  end

  always_comb begin
    col_count_nxt = col_count_r;
    row_count_nxt = row_count_r;
    if (col_inc >= {1'b0, extent_w_r}) begin
      col_count_nxt = '0;
      row_count_nxt = row_count_r + 1'b1;
    end else begin
      col_count_nxt = col_inc[EXTENT_W-1:0];
    end
  end

  assign q_wr.push         = in_accept && (in_cmd == CMD_PIXEL) && active && visible;
  assign q_wr.entry.row    = row_s[COORD_W-1:0];
  assign q_wr.entry.col    = col_s[COORD_W-1:0];
  assign q_wr.entry.value  = value;
  assign q_wr.entry.use_bg = use_bg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_mode_r     <= 1'b1;
      key_r         <= 8'd1;
      origin_x_r    <= '0;
      origin_y_r    <= '0;
      extent_w_r    <= '0;
      extent_h_r    <= '0;
      shape_mode_r  <= MODE_SPRITE;
      shape_color_r <= '0;
      col_count_r   <= '0;
      row_count_r   <= '0;
      rejected_r    <= 1'b1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BACKGROUND_MODE) begin
          bg_mode_r <= cfg_data[0];
        end else if (cfg_index == CFG_TRANSPARENT_KEY) begin
          key_r <= cfg_data[PIX_W-1:0];
        end
      end
      if (in_accept) begin
        if (in_cmd == CMD_START) begin
          origin_x_r    <= in_pos_x;
          origin_y_r    <= in_pos_y;
          extent_w_r    <= in_shape_width;
          extent_h_r    <= in_shape_height;
          shape_mode_r  <= mode_t'(in_mode);
          shape_color_r <= in_draw_color;
          col_count_r   <= '0;
          row_count_r   <= '0;
          rejected_r    <= off;
        end else if (active) begin
          col_count_r <= col_count_nxt;
          row_count_r <= row_count_nxt;
        end
      end
    end
  end

  a_no_push_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    rejected_r |-> !q_wr.push) else $error("beat pushed for rejected shape");

  a_push_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> (row_s < SH12 && col_s < SW12 && row_s >= 12'sd0 && col_s >= 12'sd0))
    else $error("off-screen pixel pushed");

  a_row_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    !rejected_r |-> (row_count_r <= extent_h_r)) else $error("row counter overran shape");

endmodule
`default_nettype wire

/* hw/rtl/csrb_queue.sv */
// Short register queue between front and back halves.
`default_nettype none
module csrb_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  csrb_pkg::queue_wr_t   q_wr,
  output logic                  q_full,
  output logic                  q_empty,
  input  logic                  q_pop,
  output csrb_pkg::blit_entry_t q_head
);
  import csrb_pkg::*;

  blit_entry_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;
  logic               do_pop;

  assign q_full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_empty = (count_r == '0);
  assign q_head  = mem_r[rd_ptr_r];
  assign do_pop  = q_pop && !q_empty;

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem_r[wr_ptr_r] <= q_wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (q_wr.push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (q_wr.push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!q_wr.push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_wr.push) else $error("queue overflow");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule
`default_nettype wire

/* hw/rtl/csrb_back.sv */
// Back end: frame address multiply and output register.
`default_nettype none
module csrb_back #(
  parameter int SCREEN_WIDTH = csrb_pkg::SCREEN_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  output logic                            q_pop,
  input  csrb_pkg::blit_entry_t           q_head,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [csrb_pkg::ADDR_W-1:0]     out_frame_address,
  output logic [csrb_pkg::PIX_W-1:0]      out_pixel_value,
  output logic                            out_use_background
);
  import csrb_pkg::*;

  localparam int PROD_W = 2 * COORD_W;

  logic                out_valid_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [PIX_W-1:0]    value_r;
  logic                use_bg_r;
  logic [PROD_W-1:0]   addr_full;

  assign q_pop     = !q_empty && (!out_valid_r || !out_stall);
  assign addr_full = ({{COORD_W{1'b0}}, q_head.row} * PROD_W'(SCREEN_WIDTH)) +
                     {{COORD_W{1'b0}}, q_head.col};

  always_ff @(posedge clk) begin
    if (q_pop) begin
      addr_r   <= addr_full[ADDR_W-1:0];
      value_r  <= q_head.value;
      use_bg_r <= q_head.use_bg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_address  = addr_r;
  assign out_pixel_value    = value_r;
  assign out_use_background = use_bg_r;

  a_bg_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && use_bg_r) |-> (value_r == '0)) else $error("restore beat with nonzero value");

endmodule
`default_nettype wire

/* hw/rtl/clipped_sprite_rect_blitter_core.sv */
// Top level of the clipped sprite/rectangle blitter with color key.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_valid/in_stall  | cmd, pos_x, pos_y, shape_width/height, mode, color, pixel
//  out_    | out | out_valid/out_stall| frame_address, pixel_value, use_background
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One beat per cycle while out_stall is low; visible pixels are queued, then registered.
// Front classifies in the accept cycle, a two-entry queue feeds the address multiply stage.
// in_stall rises only when the queue is full (output held by out_stall).
// Reset (rst_n low, synchronous) restores registers to background_mode 1, key 1, no shape.
// cfg_ready is always high.
`default_nettype none
module clipped_sprite_rect_blitter_core #(
  parameter int SCREEN_WIDTH  = csrb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = csrb_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_cmd,
  input  logic signed [csrb_pkg::POS_X_W-1:0] in_pos_x,
  input  logic signed [csrb_pkg::POS_Y_W-1:0] in_pos_y,
  input  logic [csrb_pkg::EXTENT_W-1:0]       in_shape_width,
  input  logic [csrb_pkg::EXTENT_W-1:0]       in_shape_height,
  input  logic [1:0]                          in_mode,
  input  logic [csrb_pkg::PIX_W-1:0]          in_draw_color,
  input  logic [csrb_pkg::PIX_W-1:0]          in_src_pixel,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [csrb_pkg::ADDR_W-1:0]         out_frame_address,
  output logic [csrb_pkg::PIX_W-1:0]          out_pixel_value,
  output logic                                out_use_background,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [csrb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [csrb_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import csrb_pkg::*;

  queue_wr_t   q_wr;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  blit_entry_t q_head;

  csrb_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_shape_width  (in_shape_width),
    .in_shape_height (in_shape_height),
    .in_mode         (in_mode),
    .in_draw_color   (in_draw_color),
    .in_src_pixel    (in_src_pixel),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_full          (q_full),
    .q_wr            (q_wr)
  );

  csrb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr    (q_wr),
    .q_full  (q_full),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_head  (q_head)
  );

  csrb_back #(
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .q_head             (q_head),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_address  (out_frame_address),
    .out_pixel_value    (out_pixel_value),
    .out_use_background (out_use_background)
  );

endmodule
`default_nettype wire
